>>> sv/cpp_pkg.sv
// cpp_pkg: shared types, codes and constants for the camera packet to polar block.
// No dependencies; imported by every module of the block.
`default_nettype none

package cpp_pkg;

  localparam int FRAC_BITS_DEFAULT = 4;

  // Configuration register indexes
  localparam logic [1:0] REG_SYNC_FIRST  = 2'd0;
  localparam logic [1:0] REG_SYNC_SECOND = 2'd1;
  localparam logic [1:0] REG_ATTACK_BLUE = 2'd2;

  // Result object codes
  localparam logic [1:0] OBJ_ATTACK = 2'd0;
  localparam logic [1:0] OBJ_DEFEND = 2'd1;
  localparam logic [1:0] OBJ_BALL   = 2'd2;

  // Coordinate pair slots, in packet order
  localparam logic [1:0] PAIR_YELLOW = 2'd0;
  localparam logic [1:0] PAIR_BLUE   = 2'd1;
  localparam logic [1:0] PAIR_BALL   = 2'd2;
  localparam int         NUM_PAIRS   = 3;

  localparam logic signed [8:0] CENTRE = 9'sd60;

  // CORDIC datapath
  localparam int CORDIC_STEPS = 23;
  localparam int PRESCALE     = 20;
  localparam int CW           = 32;
  localparam int ZW           = 26;
  localparam int ANG_FRAC     = 16;

  localparam logic signed [ZW-1:0] ANG_90  = 26'sd5898240;
  localparam logic signed [ZW-1:0] ANG_180 = 26'sd11796480;

  localparam logic signed [ZW-1:0] ATAN_LUT [CORDIC_STEPS] = '{
    26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945, 26'sd234379,
    26'sd117304,  26'sd58666,   26'sd29335,  26'sd14668,  26'sd7334,
    26'sd3667,    26'sd1833,    26'sd917,    26'sd458,    26'sd229,
    26'sd115,     26'sd57,      26'sd29,     26'sd14,     26'sd7,
    26'sd4,       26'sd2,       26'sd1
  };

  // Sum of squares of recentred coordinates fits in 17 bits
  localparam int SUMSQ_W = 17;

  typedef struct packed {
    logic [7:0] x;
    logic [7:0] y;
  } cpp_pair_t;

  typedef struct packed {
    logic signed [8:0] x;
    logic signed [8:0] y;
  } cpp_vec_t;

endpackage

`default_nettype wire

>>> sv/cpp_collect.sv
// cpp_collect: start byte search and coordinate byte store for one camera packet.
// Depends on cpp_pkg.
`default_nettype none

module cpp_collect
  import cpp_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       accept_i,
  input  wire logic [7:0] byte_i,
  input  wire logic [7:0] sync_first_i,
  input  wire logic [7:0] sync_second_i,
  input  wire logic [1:0] pair_sel_i,
  output cpp_pair_t       pair_o,
  output logic            done_o
);

  logic [2:0] phase_q, phase_d;
  logic       first_q, first_d;
  cpp_pair_t  pair_q [NUM_PAIRS];

  assign done_o = accept_i && (phase_q == 3'd6);
  assign pair_o = pair_q[pair_sel_i];

  always_comb begin
    phase_d = phase_q;
    first_d = first_q;
    if (accept_i) begin
      priority if (phase_q == 3'd0 || phase_q == 3'd7) begin
        phase_d = 3'd0;
        if (first_q && byte_i == sync_second_i) begin
          first_d = 1'b0;
          phase_d = 3'd1;
        end else begin
          first_d = (byte_i == sync_first_i);
        end
      end else if (phase_q == 3'd6) begin
        phase_d = 3'd0;
        first_d = 1'b0;
      end else begin
        phase_d = phase_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 3'd0;
      first_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      first_q <= first_d;
    end
  end

  // byte store, no reset
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      unique case (phase_q)
        3'd1:    pair_q[PAIR_YELLOW].x <= byte_i;
        3'd2:    pair_q[PAIR_YELLOW].y <= byte_i;
        3'd3:    pair_q[PAIR_BLUE].x   <= byte_i;
        3'd4:    pair_q[PAIR_BLUE].y   <= byte_i;
        3'd5:    pair_q[PAIR_BALL].x   <= byte_i;
        3'd6:    pair_q[PAIR_BALL].y   <= byte_i;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> sv/cpp_cordic.sv
// cpp_cordic: vectoring CORDIC, one micro-rotation a cycle, giving 90 - atan2(y,x).
// Depends on cpp_pkg.
`default_nettype none

module cpp_cordic
  import cpp_pkg::*;
#(
  parameter int FRACTION_BITS = FRAC_BITS_DEFAULT
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire cpp_vec_t    vec_i,
  output logic             busy_o,
  output logic [13:0]      angle_o
);

  localparam int IW   = $clog2(CORDIC_STEPS);
  localparam int AW   = ZW + 2;
  localparam int RSH  = ANG_FRAC - FRACTION_BITS;
  localparam logic signed [AW-1:0] HALF = AW'(1) << (RSH - 1);

  logic signed [CW-1:0] px_q, px_d, py_q, py_d;
  logic signed [ZW-1:0] z_q, z_d;
  logic [IW-1:0]        i_q, i_d;
  logic                 busy_q, busy_d;

  logic signed [CW-1:0] x_w, y_w, dx, dy;
  logic signed [AW-1:0] ang_w, rnd_w, sh_w;

  assign x_w = {{(CW-9){vec_i.x[8]}}, vec_i.x} <<< PRESCALE;
  assign y_w = {{(CW-9){vec_i.y[8]}}, vec_i.y} <<< PRESCALE;
  assign dx  = py_q >>> i_q;
  assign dy  = px_q >>> i_q;

  always_comb begin
    px_d   = px_q;
    py_d   = py_q;
    z_d    = z_q;
    i_d    = i_q;
    busy_d = busy_q;
    if (start_i) begin
      i_d    = '0;
      busy_d = 1'b0;
      priority if (vec_i.y == 9'sd0) begin
        z_d = vec_i.x[8] ? ANG_180 : '0;
      end else if (vec_i.x == 9'sd0) begin
        z_d = vec_i.y[8] ? -ANG_90 : ANG_90;
      end else begin
        busy_d = 1'b1;
        if (!vec_i.x[8]) begin
          px_d = x_w;
          py_d = y_w;
          z_d  = '0;
        end else if (!vec_i.y[8]) begin
          px_d = y_w;
          py_d = -x_w;
          z_d  = ANG_90;
        end else begin
          px_d = -y_w;
          py_d = x_w;
          z_d  = -ANG_90;
        end
      end
    end else if (busy_q) begin
      if (!py_q[CW-1]) begin
        px_d = px_q + dx;
        py_d = py_q - dy;
        z_d  = z_q + ATAN_LUT[i_q];
      end else begin
        px_d = px_q - dx;
        py_d = py_q + dy;
        z_d  = z_q - ATAN_LUT[i_q];
      end
      i_d = i_q + IW'(1);
      if (i_q == IW'(CORDIC_STEPS - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      i_q    <= '0;
    end else begin
      busy_q <= busy_d;
      i_q    <= i_d;
    end
  end

  always_ff @(posedge clk_i) begin
    px_q <= px_d;
    py_q <= py_d;
    z_q  <= z_d;
  end

  // bearing = 90 - atan2, round half up to the output fraction
  assign ang_w   = {{2{ANG_90[ZW-1]}}, ANG_90} - {{2{z_q[ZW-1]}}, z_q};
  assign rnd_w   = ang_w + HALF;
  assign sh_w    = rnd_w >>> RSH;
  assign angle_o = sh_w[13:0];
  assign busy_o  = busy_q;

endmodule

`default_nettype wire

>>> sv/cpp_isqrt.sv
// cpp_isqrt: sum of squares through one shared multiplier, then a digit-by-digit
// square root with round to nearest. Depends on cpp_pkg.
`default_nettype none

module cpp_isqrt
  import cpp_pkg::*;
#(
  parameter int FRACTION_BITS = FRAC_BITS_DEFAULT
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start_i,
  input  wire cpp_vec_t vec_i,
  output logic          busy_o,
  output logic [12:0]   distance_o
);

  localparam int NW = SUMSQ_W + 2 * FRACTION_BITS;
  localparam int RW = NW + 1;
  localparam int NB = (NW + 1) / 2;
  localparam logic [RW-1:0] BIT_TOP = RW'(1) << (2 * (NB - 1));

  typedef enum logic [3:0] {
    SQ_IDLE = 4'b0001,
    SQ_XX   = 4'b0010,
    SQ_YY   = 4'b0100,
    SQ_ROOT = 4'b1000
  } sq_state_e;

  sq_state_e state_q, state_d;

  logic [7:0]         ax_q, ay_q, mul_a;
  logic [15:0]        prod;
  logic [SUMSQ_W-1:0] acc_q, sum_w;
  logic [RW-1:0]      rem_q, rem_d, r_q, r_d, bit_q, bit_d, trial, dist_w;
  logic [8:0]         abs_x, abs_y;

  assign abs_x = vec_i.x[8] ? 9'(-vec_i.x) : vec_i.x;
  assign abs_y = vec_i.y[8] ? 9'(-vec_i.y) : vec_i.y;
  assign mul_a = (state_q == SQ_XX) ? ax_q : ay_q;
  assign prod  = mul_a * mul_a;
  assign sum_w = acc_q + SUMSQ_W'(prod);
  assign trial = r_q + bit_q;

  always_comb begin
    state_d = state_q;
    rem_d   = rem_q;
    r_d     = r_q;
    bit_d   = bit_q;
    unique case (state_q)
      SQ_IDLE: begin
        if (start_i) begin
          state_d = SQ_XX;
        end
      end
      SQ_XX: begin
        state_d = SQ_YY;
      end
      SQ_YY: begin
        rem_d   = RW'(sum_w) << (2 * FRACTION_BITS);
        r_d     = '0;
        bit_d   = BIT_TOP;
        state_d = SQ_ROOT;
      end
      SQ_ROOT: begin
        if (rem_q >= trial) begin
          rem_d = rem_q - trial;
          r_d   = (r_q >> 1) + bit_q;
        end else begin
          r_d   = r_q >> 1;
        end
        bit_d = bit_q >> 2;
        if (bit_q == RW'(1)) begin
          state_d = SQ_IDLE;
        end
      end
      default: state_d = SQ_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SQ_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && state_q == SQ_IDLE) begin
      ax_q <= abs_x[7:0];
      ay_q <= abs_y[7:0];
    end
    if (state_q == SQ_XX) begin
      acc_q <= SUMSQ_W'(prod);
    end
    rem_q <= rem_d;
    r_q   <= r_d;
    bit_q <= bit_d;
  end

  // rem holds n - r*r once the digits are done
  assign dist_w     = r_q + RW'(rem_q > r_q);
  assign distance_o = dist_w[12:0];
  assign busy_o     = (state_q != SQ_IDLE);

endmodule

`default_nettype wire

>>> sv/camera_packet_to_polar.sv
// camera_packet_to_polar: top level, configuration registers, result sequencer
// and output register. Depends on cpp_pkg, cpp_collect, cpp_cordic, cpp_isqrt.
//
// Camera bytes are taken one per cycle while the block hunts for the two start
// bytes and collects the six coordinate bytes. The sixth byte starts three
// conversions in turn (attack goal, defend goal, ball); each runs the 23-step
// CORDIC loop unless the point lies on an axis, with the square root running
// alongside. The input is stalled after the sixth byte until the ball result
// enters the output register, longer if the output side holds back results. The
// last result may still sit in the output register while new bytes are accepted.
`default_nettype none

module camera_packet_to_polar
  import cpp_pkg::*;
#(
  parameter int FRACTION_BITS = FRAC_BITS_DEFAULT
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [7:0]  cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  data_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       object_id_o,
  output logic signed [13:0] angle_o,
  output logic [12:0]      distance_o,
  output logic             visible_o,
  output logic             last_o
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_LOAD = 4'b0010,
    ST_RUN  = 4'b0100,
    ST_EMIT = 4'b1000
  } cpp_state_e;

  cpp_state_e state_q, state_d;

  logic [7:0] sync_first_q, sync_second_q;
  logic       attack_blue_q;

  logic [1:0] obj_q, obj_d, pair_sel;
  logic       vis_q;
  logic       accept, pkt_done, out_free;
  logic       cordic_busy, sqrt_busy, start;
  cpp_pair_t  pair;
  cpp_vec_t   vec;
  logic [13:0] angle_w;
  logic [12:0] dist_w;

  logic        out_valid_q;
  logic [1:0]  object_id_q;
  logic [13:0] angle_q;
  logic [12:0] distance_q;
  logic        visible_q, last_q;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign start      = (state_q == ST_LOAD);
  assign out_free   = !out_valid_q || !out_stall_i;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_first_q  <= 8'd0;
      sync_second_q <= 8'd0;
      attack_blue_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_SYNC_FIRST:  sync_first_q  <= cfg_data_i;
        REG_SYNC_SECOND: sync_second_q <= cfg_data_i;
        REG_ATTACK_BLUE: attack_blue_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  cpp_collect u_collect (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .byte_i        (data_byte_i),
    .sync_first_i  (sync_first_q),
    .sync_second_i (sync_second_q),
    .pair_sel_i    (pair_sel),
    .pair_o        (pair),
    .done_o        (pkt_done)
  );

  always_comb begin
    unique case (obj_q)
      OBJ_ATTACK: pair_sel = attack_blue_q ? PAIR_BLUE : PAIR_YELLOW;
      OBJ_DEFEND: pair_sel = attack_blue_q ? PAIR_YELLOW : PAIR_BLUE;
      default:    pair_sel = PAIR_BALL;
    endcase
  end

  // recentre a pair whose x is nonzero
  always_comb begin
    if (pair.x != 8'd0) begin
      vec.x = $signed({1'b0, pair.x}) - CENTRE;
      vec.y = $signed({1'b0, pair.y}) - CENTRE;
    end else begin
      vec.x = $signed({1'b0, pair.x});
      vec.y = $signed({1'b0, pair.y});
    end
  end

  cpp_cordic #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .vec_i   (vec),
    .busy_o  (cordic_busy),
    .angle_o (angle_w)
  );

  cpp_isqrt #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .vec_i      (vec),
    .busy_o     (sqrt_busy),
    .distance_o (dist_w)
  );

  always_comb begin
    state_d = state_q;
    obj_d   = obj_q;
    unique case (state_q)
      ST_IDLE: begin
        if (pkt_done) begin
          obj_d   = OBJ_ATTACK;
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: state_d = ST_RUN;
      ST_RUN: begin
        if (!cordic_busy && !sqrt_busy) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          if (obj_q == OBJ_BALL) begin
            state_d = ST_IDLE;
          end else begin
            obj_d   = obj_q + 2'd1;
            state_d = ST_LOAD;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      obj_q       <= OBJ_ATTACK;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      obj_q   <= obj_d;
      if (state_q == ST_EMIT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_LOAD) begin
      vis_q <= (vec.y != 9'sd0);
    end
    if (state_q == ST_EMIT && out_free) begin
      object_id_q <= obj_q;
      angle_q     <= angle_w;
      distance_q  <= dist_w;
      visible_q   <= vis_q;
      last_q      <= (obj_q == OBJ_BALL);
    end
  end

  assign out_valid_o = out_valid_q;
  assign object_id_o = object_id_q;
  assign angle_o     = angle_q;
  assign distance_o  = distance_q;
  assign visible_o   = visible_q;
  assign last_o      = last_q;

endmodule

`default_nettype wire

>>> tb/polar_result_checker.sv
`timescale 1ns / 100ps
// polar_result_checker: watches the byte and result channels of camera_packet_to_polar,
// predicts the polar results of each packet and compares them in order.
// Depends on cpp_pkg for register indexes and object codes.

module polar_result_checker
  import cpp_pkg::*;
#(
  parameter int FRACTION_BITS = FRAC_BITS_DEFAULT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_index_i,
  input  logic [7:0]        cfg_data_i,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  logic [7:0]        data_byte_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  logic [1:0]        object_id_i,
  input  logic signed [13:0] angle_i,
  input  logic [12:0]       distance_i,
  input  logic              visible_i,
  input  logic              last_i,
  output int                mismatch_count_o,
  output int                pending_o
);

  typedef longint unsigned u64_t;

  typedef struct packed {
    logic [1:0]        object_id;
    logic signed [13:0] angle;
    logic [12:0]       distance;
    logic              visible;
    logic              last;
  } polar_fix_t;

  localparam longint DEG        = 65536;

  logic [7:0] sync_first_q;
  logic [7:0] sync_second_q;
  logic       attack_blue_q;
  int         collect_pos;
  logic       first_seen;
  logic [7:0] coord_bytes [6];
  polar_fix_t polar_q [$];
  int         mismatches;

  function automatic longint atan_step(int i);
    case (i)
      0:  return 2949120;
      1:  return 1740967;
      2:  return 919879;
      3:  return 466945;
      4:  return 234379;
      5:  return 117304;
      6:  return 58666;
      7:  return 29335;
      8:  return 14668;
      9:  return 7334;
      10: return 3667;
      11: return 1833;
      12: return 917;
      13: return 458;
      14: return 229;
      15: return 115;
      16: return 57;
      17: return 29;
      18: return 14;
      19: return 7;
      20: return 4;
      21: return 2;
      default: return 1;
    endcase
  endfunction

  // atan2(y, x) in degrees * 2^16, vectoring in the right half plane
  function automatic longint cordic_bearing(longint x, longint y);
    longint px, py, z, t, dx, dy;
    if (y == 0) return (x < 0) ? 180 * DEG : 0;
    if (x == 0) return (y > 0) ? 90 * DEG : -90 * DEG;
    px = x * (longint'(1) << 20);
    py = y * (longint'(1) << 20);
    z  = 0;
    if (px < 0) begin
      if (py >= 0) begin
        t = px; px = py; py = -t; z = 90 * DEG;
      end else begin
        t = px; px = -py; py = t; z = -90 * DEG;
      end
    end
    for (int i = 0; i < 23; i++) begin
      dx = py >>> i;
      dy = px >>> i;
      if (py >= 0) begin
        px += dx; py -= dy; z += atan_step(i);
      end else begin
        px -= dx; py += dy; z -= atan_step(i);
      end
    end
    return z;
  endfunction

  function automatic u64_t round_sqrt(u64_t n);
    u64_t rem, r, step_bit;
    rem = n;
    r = 0;
    step_bit = u64_t'(1) << 62;
    while (step_bit > n) step_bit >>= 2;
    while (step_bit != 0) begin
      if (rem >= r + step_bit) begin
        rem -= r + step_bit;
        r = (r >> 1) + step_bit;
      end else begin
        r >>= 1;
      end
      step_bit >>= 2;
    end
    if (n - r * r > r) r++;
    return r;
  endfunction

  function automatic polar_fix_t to_polar(logic [1:0] id, logic [7:0] rx, logic [7:0] ry,
                                          logic is_last);
    longint x, y, ang;
    u64_t dist_val;
    polar_fix_t res;
    x = rx;
    y = ry;
    if (x != 0) begin
      x -= 60;
      y -= 60;
    end
    ang = 90 * DEG - cordic_bearing(x, y);
    ang = (ang * (longint'(1) << FRACTION_BITS) + (longint'(1) << 15)) >>> 16;
    dist_val = round_sqrt(u64_t'(x * x + y * y) << (2 * FRACTION_BITS));
    res.object_id = id;
    res.angle     = ang[13:0];
    res.distance  = dist_val[12:0];
    res.visible   = (y != 0);
    res.last      = is_last;
    return res;
  endfunction

  task automatic take_byte(input logic [7:0] b);
    int att, def;
    if (collect_pos == 0) begin
      if (first_seen && b == sync_second_q) begin
        first_seen  = 1'b0;
        collect_pos = 1;
      end else begin
        first_seen = (b == sync_first_q);
      end
    end else begin
      coord_bytes[collect_pos - 1] = b;
      if (collect_pos < 6) begin
        collect_pos++;
      end else begin
        collect_pos = 0;
        first_seen  = 1'b0;
        att = attack_blue_q ? int'(PAIR_BLUE) : int'(PAIR_YELLOW);
        def = attack_blue_q ? int'(PAIR_YELLOW) : int'(PAIR_BLUE);
        polar_q.push_back(to_polar(OBJ_ATTACK, coord_bytes[2*att], coord_bytes[2*att+1], 1'b0));
        polar_q.push_back(to_polar(OBJ_DEFEND, coord_bytes[2*def], coord_bytes[2*def+1], 1'b0));
        polar_q.push_back(to_polar(OBJ_BALL, coord_bytes[2*PAIR_BALL],
                                   coord_bytes[2*PAIR_BALL+1], 1'b1));
      end
    end
  endtask

  task automatic compare_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $display("%0t ns %s: expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_result();
    polar_fix_t want;
    if (polar_q.size() == 0) begin
      $display("%0t ns result with none expected: expected none, got id %0d angle %0d dist %0d",
               $time, object_id_i, angle_i, distance_i);
      mismatches++;
    end else begin
      want = polar_q.pop_front();
      compare_field("object_id", want.object_id, object_id_i);
      compare_field("angle", longint'($signed(want.angle)), longint'(angle_i));
      compare_field("distance", want.distance, distance_i);
      compare_field("visible", want.visible, visible_i);
      compare_field("last", want.last, last_i);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_first_q  = 8'd0;
      sync_second_q = 8'd0;
      attack_blue_q = 1'b1;
      collect_pos   = 0;
      first_seen    = 1'b0;
      mismatches    = 0;
      polar_q.delete();
      mismatch_count_o <= 0;
      pending_o        <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) check_result();
      if (in_valid_i && !in_stall_i) take_byte(data_byte_i);
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_SYNC_FIRST:  sync_first_q  = cfg_data_i;
          REG_SYNC_SECOND: sync_second_q = cfg_data_i;
          REG_ATTACK_BLUE: attack_blue_q = cfg_data_i[0];
          default: ;
        endcase
      end
      mismatch_count_o <= mismatches;
      pending_o        <= polar_q.size();
    end
  end

endmodule

>>> tb/tb_camera_packet_to_polar.sv
`timescale 1ns / 100ps
// tb_camera_packet_to_polar: drives camera byte streams, register settings and output
// back-pressure into camera_packet_to_polar and gives the verdict.
// Depends on cpp_pkg, camera_packet_to_polar and polar_result_checker.

module tb_camera_packet_to_polar;
  import cpp_pkg::*;

  localparam int SETTLE_CYCLES = 120;
  localparam int HOLD_CYCLES   = 400;
  localparam int STALL_LIMIT   = 3000;
  localparam int PHASE_BYTES   = 125;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [1:0]        cfg_index_i;
  logic [7:0]        cfg_data_i;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [7:0]        data_byte_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [1:0]        object_id_o;
  logic signed [13:0] angle_o;
  logic [12:0]       distance_o;
  logic              visible_o;
  logic              last_o;

  int         mismatch_count;
  int         pending_count;
  int         gap_odds;
  int         stall_odds;
  logic       hold_req;
  logic [7:0] sync_first_now;
  logic [7:0] sync_second_now;

  // origin, raw origin, far corner; sliding search over a repeated first byte; axis points
  logic [7:0] opening_stream [27] = '{
    8'hAA, 8'h55, 8'd60, 8'd60, 8'd0, 8'd0, 8'd255, 8'd255,
    8'hAA, 8'hAA, 8'h55, 8'd0, 8'd200, 8'd30, 8'd60, 8'd200, 8'd60,
    8'hAA, 8'h13, 8'hAA, 8'h55, 8'd1, 8'd0, 8'd60, 8'd0, 8'd60, 8'd255
  };

  camera_packet_to_polar i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .data_byte_i (data_byte_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .object_id_o (object_id_o),
    .angle_o     (angle_o),
    .distance_o  (distance_o),
    .visible_o   (visible_o),
    .last_o      (last_o)
  );

  polar_result_checker i_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .data_byte_i      (data_byte_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .object_id_i      (object_id_o),
    .angle_i          (angle_o),
    .distance_i       (distance_o),
    .visible_i        (visible_o),
    .last_i           (last_o),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic [7:0] pick_coord();
    case ($urandom_range(0, 9))
      0: return 8'd0;
      1: return 8'd60;
      2: return 8'd255;
      3: return 8'd1;
      4: return 8'($urandom_range(59, 61));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // one request per byte; valid stays up across back-to-back requests
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      gap = $urandom_range(1, 18);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_config(input logic [7:0] first, input logic [7:0] second,
                              input logic blue);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= REG_SYNC_FIRST;
    cfg_data_i  <= first;
    @(posedge clk_i);
    cfg_index_i <= REG_SYNC_SECOND;
    cfg_data_i  <= second;
    @(posedge clk_i);
    cfg_index_i <= REG_ATTACK_BLUE;
    cfg_data_i  <= {7'd0, blue};
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sync_first_now  = first;
    sync_second_now = second;
  endtask

  // mostly clean packets, some noise and truncated headers
  task automatic random_packets(input int byte_target);
    int sent, kind;
    sent = 0;
    while (sent < byte_target) begin
      kind = $urandom_range(0, 9);
      if (kind < 8) begin
        send_byte(sync_first_now);
        send_byte(sync_second_now);
        repeat (6) send_byte(pick_coord());
        sent += 8;
      end else if (kind == 8) begin
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
      end else begin
        send_byte(sync_first_now);
        send_byte(8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin : stimulus
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_index_i <= REG_SYNC_FIRST;
    cfg_data_i  <= 8'd0;
    in_valid_i  <= 1'b0;
    data_byte_i <= 8'd0;
    stall_odds  <= 0;
    hold_req    <= 1'b0;
    gap_odds = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_config(8'hAA, 8'h55, 1'b1);
    foreach (opening_stream[k]) send_byte(opening_stream[k]);
    drain();

    write_config(8'h00, 8'hFF, 1'b0);
    gap_odds = 4;
    stall_odds <= 4;
    random_packets(PHASE_BYTES);
    drain();

    write_config(8'hFF, 8'h00, 1'b1);
    gap_odds = 6;
    stall_odds <= 6;
    hold_req <= 1'b1;
    random_packets(PHASE_BYTES);
    drain();

    write_config(8'h7E, 8'h7E, 1'b0);
    gap_odds = 0;
    stall_odds <= 3;
    random_packets(PHASE_BYTES);
    drain();

    write_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 1'($urandom_range(0, 1)));
    gap_odds = 0;
    stall_odds <= 0;
    random_packets(PHASE_BYTES);
    drain();

    if (mismatch_count == 0 && pending_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin : receiver
    int burst;
    bit hold_done;
    hold_done = 1'b0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        // long hold-off so the block backs up onto its byte input
        hold_done = 1'b1;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
        burst = $urandom_range(1, 18);
        out_stall_i <= 1'b1;
        repeat (burst) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    @(posedge rst_ni);
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
